/* rtl/core/superio_config_space_defines.svh */
// assertion macros for the super i/o configuration space
`ifndef SUPERIO_CONFIG_SPACE_DEFINES_SVH
`define SUPERIO_CONFIG_SPACE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define SCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every clock edge, reset included
`define SCS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SCS_ASSERT(lbl, prop, msg)
`define SCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/scs_pkg.sv */
`timescale 1ns / 1ps
package scs_pkg;

   // sizes
   localparam int BANK_BYTES          = 256;
   localparam int BANK_IDX_W          = 8;
   localparam int DEVICE_COUNT_DEF    = 12;
   localparam int GLOBAL_BYTES_DEF    = 48;

   // access kind and port, as carried in tuser
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // index port keys
   localparam logic [7:0] KEY_OPEN  = 8'h55;
   localparam logic [7:0] KEY_CLOSE = 8'hAA;

   // global bytes
   localparam logic [7:0] G_DEVSEL = 8'h07;
   localparam logic [7:0] G_ID     = 8'h20;
   localparam logic [7:0] G_REV    = 8'h21;
   localparam logic [7:0] G_PORT   = 8'h26;
   localparam logic [7:0] ID_VALUE   = 8'h51;
   localparam logic [7:0] REV_VALUE  = 8'h01;
   localparam logic [7:0] PORT_VALUE = 8'h2E;

   // byte returned for unmapped reads
   localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;

   // device bank offsets
   localparam logic [7:0] B_ACTIVE  = 8'h30;
   localparam logic [7:0] B_BASE_HI = 8'h60;
   localparam logic [7:0] B_BASE_LO = 8'h61;
   localparam logic [7:0] B_IRQ     = 8'h70;
   localparam logic [7:0] B_EXTRA   = 8'h72;
   localparam logic [7:0] B_DMA     = 8'h74;
   localparam logic [7:0] B_OPT     = 8'hF0;

   // where a read result comes from
   typedef enum logic [1:0] {
      SRC_BYTE,
      SRC_GLOBAL,
      SRC_BANK
   } rd_src_type;

   function automatic logic [7:0] glob_reset_byte(input logic [7:0] idx);
      logic [7:0] v;
      v = 8'h00;
      if (idx == G_ID)   v = ID_VALUE;
      if (idx == G_REV)  v = REV_VALUE;
      if (idx == G_PORT) v = PORT_VALUE;
      return v;
   endfunction

   function automatic logic [7:0] dev_byte(input logic [7:0] off, input logic [7:0] active,
                                           input logic [15:0] base, input logic [7:0] irq,
                                           input logic [7:0] dma, input logic [7:0] opt);
      logic [7:0] v;
      v = 8'h00;
      if (off == B_ACTIVE)  v = active;
      if (off == B_BASE_HI) v = base[15:8];
      if (off == B_BASE_LO) v = base[7:0];
      if (off == B_IRQ)     v = irq;
      if (off == B_DMA)     v = dma;
      if (off == B_OPT)     v = opt;
      return v;
   endfunction

   // firmware settings of the logical devices
   function automatic logic [7:0] fw_image_byte(input logic [7:0] dev, input logic [7:0] off);
      logic [7:0] v;
      case (dev)
         8'd0:    v = dev_byte(off, 8'h00, 16'h03F0, 8'd6, 8'd2, 8'h0E);
         8'd3:    v = dev_byte(off, 8'h00, 16'h0278, 8'd7, 8'd4, 8'h3C);
         8'd4:    v = dev_byte(off, 8'h01, 16'h03F8, 8'd4, 8'd4, 8'h02);
         8'd5:    v = dev_byte(off, 8'h00, 16'h02F8, 8'd3, 8'd4, 8'h02);
         8'd7: begin
            if (off == B_EXTRA) v = 8'h0C;
            else                v = dev_byte(off, 8'h01, 16'h0060, 8'd1, 8'd4, 8'h18);
         end
         8'd9:    v = dev_byte(off, 8'h00, 16'h0200, 8'd0, 8'd4, 8'h00);
         8'd10:   v = dev_byte(off, 8'h01, 16'h0800, 8'd0, 8'd4, 8'h00);
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/superio_config_space.sv */
`timescale 1ns / 1ps
// super i/o configuration space behind an index/data port pair
// req channel: one bus access per transaction; tuser carries the access kind
//   (bit 0: 0 read, 1 write) and the port (bit 1: 0 index, 1 data), tdata the
//   byte written. writing 55h to the index port opens configuration mode, AAh
//   closes it, any other byte becomes the index.
// rsp channel: one transaction per read, carrying the byte read; writes give
//   nothing back.
// timing: a read passes the registered read port of the global and bank memories,
//   then the output register; a write takes effect at the edge that accepts it.
// throughput: a write every cycle while no read is pending and the output is not
//   stalled; a new access waits until a read's result is in the output register,
//   as the block takes one access at a time, so a read never meets a pending write.
// a finished result waits in the output register; while it is stalled the
//   input is held off as well, reads and writes alike.
// reset: index, mode and device select clear, then a load pass over all
//   DEVICE_COUNT * 256 bank bytes (3072 by default) writes the firmware settings
//   into the device banks and the reset values into the global bytes;
//   req_tready stays low during the pass.
module superio_config_space #(
   parameter int DEVICE_COUNT = scs_pkg::DEVICE_COUNT_DEF,
   parameter int GLOBAL_BYTES = scs_pkg::GLOBAL_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] write_data
   input  logic [1:0] req_tuser,   // [0] mode, [1] port_select
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] read_data
);
   import scs_pkg::*;

`include "superio_config_space_defines.svh"

   localparam int DEV_W      = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
   localparam int BANK_AW    = DEV_W + BANK_IDX_W;
   localparam int BANK_DEPTH = DEVICE_COUNT * BANK_BYTES;
   localparam int GLOB_AW    = $clog2(GLOBAL_BYTES);
   localparam logic [BANK_AW-1:0] SWEEP_LAST = BANK_AW'(BANK_DEPTH - 1);

   // storage
   logic [7:0] glob_mem [GLOBAL_BYTES];
   logic [7:0] bank_mem [BANK_DEPTH];

   // control registers
   logic               config_open_ff, config_open_in;
   logic [7:0]         index_ff, index_in;
   logic [7:0]         devsel_ff, devsel_in;   // shadow of global byte 07h
   logic [BANK_AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic               sweep_done_ff, sweep_done_in;
   logic               pend_ff, pend_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;

   // payload registers
   rd_src_type pend_src_ff, pend_src_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic [7:0] glob_rd_ff;
   logic [7:0] bank_rd_ff;

   // decode of the current transaction
   logic       req_fire;
   logic       is_write;
   logic       is_data;
   logic [7:0] wd;
   logic       idx_glob;
   logic       dev_ok;
   logic       glob_we, bank_we, glob_re, bank_re;
   logic [BANK_AW-1:0] bank_addr;
   logic [BANK_AW-1:0] bank_waddr;
   logic [7:0]         bank_wdata;
   logic [GLOB_AW-1:0] glob_waddr;
   logic [7:0]         glob_wdata;
   logic               glob_wen;

   assign req_tready = sweep_done_ff && !pend_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign is_write   = (req_tuser[0] == MODE_WRITE);
   assign is_data    = (req_tuser[1] == PORT_DATA);
   assign wd         = req_tdata;
   assign idx_glob   = index_ff < 8'(GLOBAL_BYTES);
   assign dev_ok     = {1'b0, devsel_ff} < 9'(DEVICE_COUNT);
   assign bank_addr  = {devsel_ff[DEV_W-1:0], index_ff};

   assign glob_we = req_fire && is_write && is_data && config_open_ff && idx_glob
                    && index_ff != G_ID && index_ff != G_REV;
   assign bank_we = req_fire && is_write && is_data && config_open_ff && !idx_glob && dev_ok;
   assign glob_re = req_fire && !is_write && is_data && idx_glob;
   assign bank_re = req_fire && !is_write && is_data && !idx_glob;

   // write port shared between the load pass and bus writes
   always_comb begin
      if (!sweep_done_ff) begin
         bank_waddr = sweep_cnt_ff;
         bank_wdata = fw_image_byte(8'(sweep_cnt_ff[BANK_AW-1:BANK_IDX_W]),
                                    sweep_cnt_ff[BANK_IDX_W-1:0]);
         glob_waddr = sweep_cnt_ff[GLOB_AW-1:0];
         glob_wdata = glob_reset_byte(8'(sweep_cnt_ff[GLOB_AW-1:0]));
         glob_wen   = sweep_cnt_ff < BANK_AW'(GLOBAL_BYTES);
      end else begin
         bank_waddr = bank_addr;
         bank_wdata = wd;
         glob_waddr = index_ff[GLOB_AW-1:0];
         glob_wdata = wd;
         glob_wen   = glob_we;
      end
   end

   always_ff @(posedge clock) begin
      if (!sweep_done_ff || bank_we) begin
         bank_mem[bank_waddr] <= bank_wdata;
      end
      if (bank_re) begin
         bank_rd_ff <= bank_mem[bank_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (glob_wen) begin
         glob_mem[glob_waddr] <= glob_wdata;
      end
      if (glob_re) begin
         glob_rd_ff <= glob_mem[index_ff[GLOB_AW-1:0]];
      end
   end

   // next state
   always_comb begin
      config_open_in = config_open_ff;
      index_in       = index_ff;
      devsel_in      = devsel_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      sweep_done_in  = sweep_done_ff;
      pend_in        = 1'b0;
      pend_src_in    = pend_src_ff;
      pend_byte_in   = pend_byte_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;

      if (!sweep_done_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == SWEEP_LAST) begin
            sweep_done_in = 1'b1;
         end
      end

      // index port writes: keys switch the mode, anything else is the index
      if (req_fire && is_write && !is_data) begin
         if (wd == KEY_OPEN) begin
            config_open_in = 1'b1;
         end else if (wd == KEY_CLOSE) begin
            config_open_in = 1'b0;
         end else begin
            index_in = wd;
         end
      end

      if (glob_we && index_ff == G_DEVSEL) begin
         devsel_in = wd;
      end

      // reads: pick the source now, the memory data arrives next cycle
      if (req_fire && !is_write) begin
         pend_in      = 1'b1;
         pend_src_in  = SRC_BYTE;
         pend_byte_in = BYTE_UNMAPPED;
         if (!is_data) begin
            pend_byte_in = index_ff;
         end else if (config_open_ff && idx_glob) begin
            pend_src_in = SRC_GLOBAL;
         end else if (config_open_ff && dev_ok) begin
            pend_src_in = SRC_BANK;
         end
      end

      // output register
      if (pend_ff) begin
         rsp_tvalid_in = 1'b1;
         case (pend_src_ff)
            SRC_GLOBAL: rsp_tdata_in = glob_rd_ff;
            SRC_BANK:   rsp_tdata_in = bank_rd_ff;
            default:    rsp_tdata_in = pend_byte_ff;
         endcase
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         config_open_ff <= 1'b0;
         index_ff       <= 8'h00;
         devsel_ff      <= 8'h00;
         sweep_cnt_ff   <= '0;
         sweep_done_ff  <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         config_open_ff <= config_open_in;
         index_ff       <= index_in;
         devsel_ff      <= devsel_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         sweep_done_ff  <= sweep_done_in;
         pend_ff        <= pend_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_src_ff  <= pend_src_in;
      pend_byte_ff <= pend_byte_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks
   `SCS_ASSERT_ALWAYS(a_no_accept_in_sweep,
                      !sweep_done_ff |-> !req_tready, "accept during load pass")
   `SCS_ASSERT(a_pend_finds_room,
               pend_ff |-> !rsp_tvalid_ff, "pending read meets a full output")
   `SCS_ASSERT(a_pend_delivers, pend_ff |=> rsp_tvalid_ff, "pending read not delivered")
   `SCS_ASSERT(a_closed_read_ff,
               req_fire && !is_write && is_data && !config_open_ff
               |-> ##2 rsp_tdata_ff == BYTE_UNMAPPED, "closed data read not FFh")
   `SCS_ASSERT(a_key_keeps_index,
               req_fire && is_write && !is_data && (wd == KEY_OPEN || wd == KEY_CLOSE)
               |=> $stable(index_ff), "key byte changed the index")

endmodule
